// ----- rtl/core/ffbb_pkg.sv -----
package ffbb_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_W-1:0] IMAGE_SIZE_RESET = 9'd256;

  typedef struct packed {
    logic load_wr;
    logic query_start;
    logic clr_step;
    logic seed_rd;
    logic seed_push;
    logic pop_rd;
    logic cur_rd;
    logic cur_take;
    logic nb_rd;
    logic nb_push;
    logic out_load;
  } ffbb_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic seed_ok;
    logic q_empty;
    logic cur_opaque;
    logic nb_last;
    logic out_free;
  } ffbb_status_t;

endpackage

// ----- rtl/core/ffbb_datapath.sv -----
module ffbb_datapath #(
  parameter int MAX_WIDTH  = ffbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ffbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffbb_pkg::ffbb_cmd_t           cmd,
  output ffbb_pkg::ffbb_status_t        status,
  input  logic [7:0]                    in_pos_x,
  input  logic [7:0]                    in_pos_y,
  input  logic [7:0]                    in_alpha,
  input  logic                          cfg_wr_en,
  input  logic [ffbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffbb_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [31:0]                   out_tdata,
  output logic                          out_tuser
);
  import ffbb_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int AW    = XW + YW;
  localparam int DEPTH = 1 << AW;
  localparam logic [8:0] MW9 = (MAX_WIDTH  > 256) ? 9'd256 : 9'(MAX_WIDTH);
  localparam logic [8:0] MH9 = (MAX_HEIGHT > 256) ? 9'd256 : 9'(MAX_HEIGHT);

  function automatic logic [AW-1:0] pix_addr(input logic [7:0] x, input logic [7:0] y);
    return {YW'(y), XW'(x)};
  endfunction

  logic opq_mem [DEPTH];
  logic vis_mem [DEPTH];
  logic [15:0] q_mem [DEPTH];

  logic [8:0] image_width_r, image_height_r;
  logic [8:0] w_r, h_r;
  logic [7:0] seed_x_r, seed_y_r;
  logic       seed_in_r;
  logic [7:0] clr_x_r, clr_y_r;
  logic [AW:0] head_r, tail_r;
  logic [7:0] cur_x_r, cur_y_r;
  logic [1:0] nb_idx_r;
  logic [7:0] left_r, right_r, top_r, bottom_r;
  logic       opaque_r;
  logic       opq_rd_r, vis_rd_r;
  logic [15:0] q_rd_r;
  logic       out_valid_r;
  logic [31:0] out_data_r;
  logic       out_user_r;

  logic [8:0] w_eff, h_eff;
  logic [7:0] nb_x, nb_y;
  logic       nb_valid, nb_new;
  logic [AW-1:0] opq_raddr, vis_waddr;
  logic       vis_we, vis_wdata, q_we;
  logic [15:0] q_wdata;
  logic       load_in;

  assign w_eff = (image_width_r  > MW9) ? MW9 : image_width_r;
  assign h_eff = (image_height_r > MH9) ? MH9 : image_height_r;
  assign load_in = (32'(in_pos_x) < MAX_WIDTH) && (32'(in_pos_y) < MAX_HEIGHT);

  always_comb begin
    nb_x = cur_x_r;
    nb_y = cur_y_r;
    nb_valid = 1'b0;
    case (nb_idx_r)
      2'd0: begin
        nb_x = cur_x_r - 8'd1;
        nb_valid = (cur_x_r != 8'd0);
      end
      2'd1: begin
        nb_y = cur_y_r + 8'd1;
        nb_valid = ({1'b0, cur_y_r} + 9'd1) < h_r;
      end
      2'd2: begin
        nb_y = cur_y_r - 8'd1;
        nb_valid = (cur_y_r != 8'd0);
      end
      default: begin
        nb_x = cur_x_r + 8'd1;
        nb_valid = ({1'b0, cur_x_r} + 9'd1) < w_r;
      end
    endcase
  end

  assign nb_new = nb_valid && !vis_rd_r;

  // visited write port shared by clearing, seed push and neighbor push
  always_comb begin
    vis_we = 1'b0;
    vis_wdata = 1'b1;
    vis_waddr = pix_addr(nb_x, nb_y);
    q_we = 1'b0;
    q_wdata = {nb_y, nb_x};
    if (cmd.clr_step) begin
      vis_we = (w_r != 9'd0) && (h_r != 9'd0);
      vis_wdata = 1'b0;
      vis_waddr = pix_addr(clr_x_r, clr_y_r);
    end else if (cmd.seed_push) begin
      vis_we = 1'b1;
      vis_waddr = pix_addr(seed_x_r, seed_y_r);
      q_we = 1'b1;
      q_wdata = {seed_y_r, seed_x_r};
    end else if (cmd.nb_push) begin
      vis_we = nb_new;
      q_we = nb_new;
    end
  end

  assign opq_raddr = cmd.seed_rd ? pix_addr(seed_x_r, seed_y_r)
                                 : pix_addr(q_rd_r[7:0], q_rd_r[15:8]);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_in) opq_mem[pix_addr(in_pos_x, in_pos_y)] <= (in_alpha != 8'd0);
    if (cmd.seed_rd || cmd.cur_rd) opq_rd_r <= opq_mem[opq_raddr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    if (cmd.nb_rd) vis_rd_r <= vis_mem[pix_addr(nb_x, nb_y)];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[tail_r[AW-1:0]] <= q_wdata;
    if (cmd.pop_rd) q_rd_r <= q_mem[head_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_SIZE_RESET;
      image_height_r <= IMAGE_SIZE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      nb_idx_r <= 2'd0;
      opaque_r <= 1'b0;
      left_r <= 8'd0;
      right_r <= 8'd0;
      top_r <= 8'd0;
      bottom_r <= 8'd0;
    end else begin
      if (cmd.query_start) begin
        w_r <= w_eff;
        h_r <= h_eff;
        seed_x_r <= in_pos_x;
        seed_y_r <= in_pos_y;
        seed_in_r <= ({1'b0, in_pos_x} < w_eff) && ({1'b0, in_pos_y} < h_eff);
        clr_x_r <= 8'd0;
        clr_y_r <= 8'd0;
        head_r <= '0;
        tail_r <= '0;
        opaque_r <= 1'b0;
        left_r <= in_pos_x;
        right_r <= in_pos_x;
        top_r <= in_pos_y;
        bottom_r <= in_pos_y;
      end
      if (cmd.clr_step) begin
        if ({1'b0, clr_x_r} + 9'd1 >= w_r) begin
          clr_x_r <= 8'd0;
          clr_y_r <= clr_y_r + 8'd1;
        end else begin
          clr_x_r <= clr_x_r + 8'd1;
        end
      end
      if (cmd.seed_push) opaque_r <= 1'b1;
      if (q_we) tail_r <= tail_r + 1'b1;
      if (cmd.pop_rd) head_r <= head_r + 1'b1;
      if (cmd.cur_rd) begin
        cur_x_r <= q_rd_r[7:0];
        cur_y_r <= q_rd_r[15:8];
      end
      if (cmd.cur_take) begin
        nb_idx_r <= 2'd0;
        if (opq_rd_r) begin
          if (cur_x_r < left_r)   left_r   <= cur_x_r;
          if (cur_x_r > right_r)  right_r  <= cur_x_r;
          if (cur_y_r < top_r)    top_r    <= cur_y_r;
          if (cur_y_r > bottom_r) bottom_r <= cur_y_r;
        end
      end
      if (cmd.nb_push) nb_idx_r <= nb_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {bottom_r - top_r, right_r - left_r, top_r, left_r};
      out_user_r <= opaque_r;
    end
  end

  assign status.clr_last   = (w_r == 9'd0) || (h_r == 9'd0) ||
                             (({1'b0, clr_x_r} + 9'd1 == w_r) &&
                              ({1'b0, clr_y_r} + 9'd1 == h_r));
  assign status.seed_ok    = seed_in_r && opq_rd_r;
  assign status.q_empty    = (head_r == tail_r);
  assign status.cur_opaque = opq_rd_r;
  assign status.nb_last    = (nb_idx_r == 2'd3);
  assign status.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- rtl/core/ffbb_ctrl.sv -----
module ffbb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_op,
  output logic                   in_tready,
  output ffbb_pkg::ffbb_cmd_t    cmd,
  input  ffbb_pkg::ffbb_status_t status
);
  import ffbb_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CLEAR    = 10'b0000000010,
    S_SEED_RD  = 10'b0000000100,
    S_SEED_CHK = 10'b0000001000,
    S_POP      = 10'b0000010000,
    S_POP_WAIT = 10'b0000100000,
    S_POP_CHK  = 10'b0001000000,
    S_NB_RD    = 10'b0010000000,
    S_NB_CHK   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_op == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_nxt = S_SEED_RD;
      end
      S_SEED_RD: begin
        cmd.seed_rd = 1'b1;
        state_nxt = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        if (status.seed_ok) begin
          cmd.seed_push = 1'b1;
          state_nxt = S_POP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        if (status.q_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.cur_rd = 1'b1;
        state_nxt = S_POP_CHK;
      end
      S_POP_CHK: begin
        cmd.cur_take = 1'b1;
        state_nxt = status.cur_opaque ? S_NB_RD : S_POP;
      end
      S_NB_RD: begin
        cmd.nb_rd = 1'b1;
        state_nxt = S_NB_CHK;
      end
      S_NB_CHK: begin
        cmd.nb_push = 1'b1;
        state_nxt = status.nb_last ? S_POP : S_NB_RD;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- rtl/core/flood_fill_bounding_box.sv -----
// four-neighbor flood fill with bounding box result
// input channel: in_tuser selects load (0) or query (1); in_tdata carries the
// pixel coordinate and alpha. a load stores one opacity bit, keeps the input
// ready and returns nothing. a query seeds a breadth-first fill over opaque
// pixels inside the configured image and returns one result transaction.
// output channel: left/top corner and spans of the reached region; out_tuser
// flags an opaque seed inside the image.
// query steps: clear the visited map, read and check the seed, then for an
// opaque seed dequeue each queued pixel, check the four neighbors of each
// opaque pixel and finish on an empty queue; last, load the output register.
// input is held off (in_tready low) for the whole query.
// a finished result waits in the output register; loads are still accepted
// while it waits, a following query stalls at its end until the slot frees.
// cfg_wr_en writes image_width (index 0) or image_height (index 1) at once.
// after reset: idle, no result pending, both sizes 256, opacity map unknown.
module flood_fill_bounding_box #(
  parameter int MAX_WIDTH  = ffbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ffbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // pos_x, pos_y, alpha
  input  logic                           in_tuser,   // opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // box_left, box_top, span_x, span_y
  output logic                           out_tuser,  // seed_opaque
  input  logic                           cfg_wr_en,
  input  logic [ffbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffbb_pkg::CFG_W-1:0]     cfg_wdata
);
  import ffbb_pkg::*;

  ffbb_cmd_t    cmd;
  ffbb_status_t status;

  ffbb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .status    (status)
  );

  ffbb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_pos_x   (in_tdata[7:0]),
    .in_pos_y   (in_tdata[15:8]),
    .in_alpha   (in_tdata[23:16]),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/core/ffbb_checker.sv -----
module ffbb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);
  import ffbb_pkg::*;

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no opaque seed means a single point
  a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:16] == 16'd0)
    else $error("nonzero span for transparent seed");

  // a query transaction blocks the input for at least the next cycle
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_QUERY) |=> !in_tready)
    else $error("input ready during query");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind flood_fill_bounding_box ffbb_checker u_ffbb_checker (.*);

// ----- verif/tb_flood_fill_bounding_box.sv -----
module tb_flood_fill_bounding_box;
  import ffbb_pkg::*;

  typedef struct {
    logic       op;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] al;
  } pix_item_t;

  typedef struct {
    logic [7:0] left;
    logic [7:0] top;
    logic [7:0] span_x;
    logic [7:0] span_y;
    logic       opaque;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  flood_fill_bounding_box uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pix_item_t pending_pix[$];
  box_t      boxes_due[$];
  bit        opac_bits[0:65535];
  bit        seen_bits[0:65535];
  int unsigned img_w = 256;
  int unsigned img_h = 256;
  int unsigned accepted = 0;
  int        errors = 0;
  int        mode = 0;
  logic      send_hold = 1'b0;
  logic      long_hold_go = 1'b0;
  logic      long_hold_done = 1'b0;
  int        long_hold_cnt = 0;
  longint    cycles = 0;

  function automatic box_t fill_box(input logic [7:0] sx, input logic [7:0] sy);
    box_t r;
    int fifo[$];
    int lft, rgt, tp, bot, a, x, y;
    lft = sx; rgt = sx; tp = sy; bot = sy;
    r.opaque = 1'b0;
    for (int j = 0; j < img_h; j++)
      for (int i = 0; i < img_w; i++) seen_bits[j*256+i] = 1'b0;
    if (sx < img_w && sy < img_h && opac_bits[sy*256+sx]) begin
      r.opaque = 1'b1;
      seen_bits[sy*256+sx] = 1'b1;
      fifo = {fifo, sy*256+sx};
      while (fifo.size() > 0) begin
        a = fifo.pop_front();
        x = a % 256;
        y = a / 256;
        if (!opac_bits[a]) continue;
        if (x < lft) lft = x;
        if (x > rgt) rgt = x;
        if (y < tp) tp = y;
        if (y > bot) bot = y;
        if (x > 0 && !seen_bits[a-1]) begin seen_bits[a-1] = 1; fifo = {fifo, a-1}; end
        if (y+1 < img_h && !seen_bits[a+256]) begin
          seen_bits[a+256] = 1; fifo = {fifo, a+256};
        end
        if (y > 0 && !seen_bits[a-256]) begin seen_bits[a-256] = 1; fifo = {fifo, a-256}; end
        if (x+1 < img_w && !seen_bits[a+1]) begin seen_bits[a+1] = 1; fifo = {fifo, a+1}; end
      end
    end
    r.left = lft[7:0];
    r.top = tp[7:0];
    r.span_x = 8'(rgt - lft);
    r.span_y = 8'(bot - tp);
    return r;
  endfunction

  function automatic bit sender_idles();
    if (mode == 0) return $urandom_range(0, 99) < 29;
    if (mode == 1) return $urandom_range(0, 99) < 74;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    pix_item_t it;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        accepted <= accepted + 1;
        if (in_tuser == OP_LOAD)
          opac_bits[in_tdata[15:8]*256 + in_tdata[7:0]] = (in_tdata[23:16] != 0);
        else
          boxes_due = {boxes_due, fill_box(in_tdata[7:0], in_tdata[15:8])};
      end
      if (!in_tvalid || in_tready) begin
        if (pending_pix.size() > 0 && !send_hold && !sender_idles()) begin
          it = pending_pix.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= it.op;
          in_tdata <= {it.al, it.py, it.px};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    box_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (boxes_due.size() == 0) begin
          $error("unexpected result transaction %h", out_tdata);
          errors++;
        end else begin
          e = boxes_due.pop_front();
          if (out_tdata[7:0] !== e.left) begin
            $error("box_left exp %0d got %0d", e.left, out_tdata[7:0]); errors++;
          end
          if (out_tdata[15:8] !== e.top) begin
            $error("box_top exp %0d got %0d", e.top, out_tdata[15:8]); errors++;
          end
          if (out_tdata[23:16] !== e.span_x) begin
            $error("span_x exp %0d got %0d", e.span_x, out_tdata[23:16]); errors++;
          end
          if (out_tdata[31:24] !== e.span_y) begin
            $error("span_y exp %0d got %0d", e.span_y, out_tdata[31:24]); errors++;
          end
          if (out_tuser !== e.opaque) begin
            $error("seed_opaque exp %0d got %0d", e.opaque, out_tuser); errors++;
          end
        end
      end
      if (long_hold_go && !long_hold_done) begin
        long_hold_done <= 1'b1;
        long_hold_cnt <= 600;
        out_tready <= 1'b0;
      end else if (long_hold_cnt > 0) begin
        long_hold_cnt <= long_hold_cnt - 1;
        out_tready <= 1'b0;
      end else if (mode == 0) out_tready <= $urandom_range(0, 99) >= 74;
      else if (mode == 1) out_tready <= $urandom_range(0, 99) >= 29;
      else out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (accepted >= 740) mode <= 2;
    else if (accepted >= 370) mode <= 1;
    if (cycles > 6000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic add_pix(input logic op, input int x, input int y, input int a);
    pix_item_t it;
    it.op = op; it.px = x[7:0]; it.py = y[7:0]; it.al = a[7:0];
    pending_pix = {pending_pix, it};
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_pix.size() > 0 || in_tvalid || boxes_due.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  // writes happen only with the block idle
  task automatic set_size(input int w, input int h);
    @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= REG_IMAGE_WIDTH; cfg_wdata <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT; cfg_wdata <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    img_w = w; img_h = h;
  endtask

  // every pixel of the image in use gets written before any query
  task automatic rand_phase(input int w, input int h, input int n, input bit hold);
    int dens, r;
    dens = $urandom_range(30, 95);
    set_size(w, h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        add_pix(OP_LOAD, x, y, ($urandom_range(0, 99) < dens) ? $urandom_range(1, 255) : 0);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        if ($urandom_range(0, 99) < 85)
          add_pix(OP_QUERY, $urandom_range(0, w-1), $urandom_range(0, h-1), $urandom_range(0, 255));
        else
          add_pix(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (r < 85) begin
        add_pix(OP_LOAD, $urandom_range(0, w-1), $urandom_range(0, h-1),
                ($urandom_range(0, 99) < dens) ? $urandom_range(1, 255) : 0);
      end else begin
        add_pix(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      end
      if (hold && k == 5) long_hold_go <= 1'b1;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // single pixel image: opaque, outside seed, transparent
    set_size(1, 1);
    add_pix(OP_LOAD, 0, 0, 255);
    add_pix(OP_QUERY, 0, 0, 0);
    add_pix(OP_QUERY, 255, 255, 255);
    add_pix(OP_QUERY, 0, 1, 0);
    add_pix(OP_LOAD, 0, 0, 0);
    add_pix(OP_QUERY, 0, 0, 0);
    drain();

    // full-width row, all opaque gives span 255
    set_size(256, 1);
    for (int x = 0; x < 256; x++) add_pix(OP_LOAD, x, 0, (x % 2) ? 1 : 255);
    add_pix(OP_QUERY, 128, 0, 0);
    add_pix(OP_QUERY, 255, 0, 0);
    add_pix(OP_LOAD, 100, 0, 0);
    add_pix(OP_QUERY, 255, 0, 0);
    add_pix(OP_QUERY, 0, 0, 0);
    add_pix(OP_QUERY, 100, 0, 0);
    drain();

    // full-height column
    set_size(1, 256);
    for (int y = 0; y < 256; y++) add_pix(OP_LOAD, 0, y, $urandom_range(1, 255));
    add_pix(OP_QUERY, 0, 255, 0);
    add_pix(OP_LOAD, 0, 40, 0);
    add_pix(OP_QUERY, 0, 0, 0);
    add_pix(OP_QUERY, 0, 255, 0);
    drain();

    rand_phase(6, 6, 60, 1'b1);
    for (int p = 0; p < 2; p++)
      rand_phase($urandom_range(1, 10), $urandom_range(1, 10), 75, 1'b0);
    rand_phase(16, 16, 40, 1'b0);

    send_hold <= 1'b0;
    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && boxes_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
